@@ src/acwa_pkg.sv @@
// Shared types and constants for the address cache with aging.
// Entry layout, field widths and register map; no dependencies.
package acwa_pkg;

  localparam int IP_W    = 32;
  localparam int MAC_W   = 48;
  localparam int TIME_W  = 32;
  localparam int PADDR_W = 3;

  localparam int DEFAULT_DEPTH = 16;

  localparam logic [TIME_W-1:0] AGE_LIMIT_RST = 32'd300;

  // register index decoded from paddr[2]
  localparam logic REG_AGE_LIMIT = 1'b0;

  typedef struct packed {
    logic [IP_W-1:0]   ip;
    logic [MAC_W-1:0]  mac;
    logic [TIME_W-1:0] stamp;
  } entry_t;

endpackage

@@ src/acwa_cfg.sv @@
// APB-style register file holding the age limit.
// Depends on acwa_pkg for widths, reset value and register index.
module acwa_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [acwa_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output logic [acwa_pkg::TIME_W-1:0]  age_limit
);

  logic [acwa_pkg::TIME_W-1:0] age_limit_r;
  logic                        sel_age;

  assign sel_age   = (paddr[2] == acwa_pkg::REG_AGE_LIMIT);
  assign pready    = 1'b1;
  assign age_limit = age_limit_r;
  assign prdata    = sel_age ? age_limit_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      age_limit_r <= acwa_pkg::AGE_LIMIT_RST;
    end else if (psel && penable && pwrite && sel_age) begin
      age_limit_r <= pwdata;
    end
  end

endmodule

@@ src/acwa_mem.sv @@
// Entry store: one write port, one read port, registered read data.
// Depends on acwa_pkg for the entry layout.
module acwa_mem #(
  parameter int DEPTH = acwa_pkg::DEFAULT_DEPTH,
  parameter int IW    = $clog2(acwa_pkg::DEFAULT_DEPTH)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [IW-1:0]       waddr,
  input  acwa_pkg::entry_t    wdata,
  input  logic [IW-1:0]       raddr,
  output acwa_pkg::entry_t    rdata
);

  acwa_pkg::entry_t mem [DEPTH];
  acwa_pkg::entry_t rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

@@ src/acwa_ctrl.sv @@
// Sequencer: search, insert and aging/compaction passes over the entry store.
// Depends on acwa_pkg; drives acwa_mem ports and holds the result register.
module acwa_ctrl #(
  parameter int DEPTH = acwa_pkg::DEFAULT_DEPTH,
  parameter int IW    = $clog2(acwa_pkg::DEFAULT_DEPTH),
  parameter int CW    = $clog2(acwa_pkg::DEFAULT_DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [acwa_pkg::IP_W-1:0]    in_sender_ip,
  input  logic [acwa_pkg::MAC_W-1:0]   in_sender_mac,
  input  logic [acwa_pkg::TIME_W-1:0]  in_now,
  input  logic [acwa_pkg::TIME_W-1:0]  age_limit,
  output logic                         mem_we,
  output logic [IW-1:0]                mem_waddr,
  output acwa_pkg::entry_t             mem_wdata,
  output logic [IW-1:0]                mem_raddr,
  input  acwa_pkg::entry_t             mem_rdata,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_was_present,
  output logic [3:0]                   out_write_slot,
  output logic [4:0]                   out_entries_after,
  output logic [4:0]                   out_removed_count
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_INSERT,
    ST_AGE,
    ST_DONE
  } state_t;

  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] LAST_C  = CW'(DEPTH - 1);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  state_t                      state_r;
  logic [CW-1:0]               entry_count_r;
  logic [CW-1:0]               count_r;
  logic [CW-1:0]               rd_idx_r;
  logic                        pend_r;
  logic [CW-1:0]               pend_idx_r;
  logic [CW-1:0]               kept_r;
  logic                        found_r;
  logic [IW-1:0]               slot_r;
  logic [acwa_pkg::IP_W-1:0]   ip_r;
  logic [acwa_pkg::MAC_W-1:0]  mac_r;
  logic [acwa_pkg::TIME_W-1:0] now_r;

  logic                        out_valid_r;
  logic                        out_present_r;
  logic [3:0]                  out_slot_r;
  logic [4:0]                  out_entries_r;
  logic [4:0]                  out_removed_r;

  logic [CW-1:0]               clamp;
  logic                        issue;
  logic                        last;
  logic                        hit;
  logic                        keep;
  logic [acwa_pkg::TIME_W-1:0] age;
  logic [CW-1:0]               removed;
  logic [IW+3:0]               slot_ext;
  logic [CW+4:0]               kept_ext;
  logic [CW+4:0]               removed_ext;

  assign clamp   = (entry_count_r >= DEPTH_C) ? LAST_C : entry_count_r;
  assign issue   = (rd_idx_r < count_r);
  assign last    = (pend_idx_r == (count_r - ONE_C));
  assign hit     = (mem_rdata.ip == ip_r);
  assign age     = now_r - mem_rdata.stamp;
  assign keep    = (age <= age_limit);
  assign removed = count_r - kept_r;

  assign slot_ext    = {4'b0, slot_r};
  assign kept_ext    = {5'b0, kept_r};
  assign removed_ext = {5'b0, removed};

  assign in_ready          = (state_r == ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_was_present   = out_present_r;
  assign out_write_slot    = out_slot_r;
  assign out_entries_after = out_entries_r;
  assign out_removed_count = out_removed_r;

  always_comb begin
    mem_raddr = rd_idx_r[IW-1:0];
    mem_we    = 1'b0;
    mem_waddr = count_r[IW-1:0];
    mem_wdata = '{ip: ip_r, mac: mac_r, stamp: now_r};
    case (state_r)
      ST_INSERT: begin
        mem_we = 1'b1;
      end
      ST_AGE: begin
        // move a survivor down over the gap left by expired entries
        if (pend_r && keep && (kept_r != pend_idx_r)) begin
          mem_we    = 1'b1;
          mem_waddr = kept_r[IW-1:0];
          mem_wdata = mem_rdata;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      entry_count_r <= '0;
      out_valid_r   <= 1'b0;
      pend_r        <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            ip_r     <= in_sender_ip;
            mac_r    <= in_sender_mac;
            now_r    <= in_now;
            count_r  <= clamp;
            slot_r   <= clamp[IW-1:0];
            found_r  <= 1'b0;
            rd_idx_r <= '0;
            pend_r   <= 1'b0;
            kept_r   <= '0;
            state_r  <= (clamp == '0) ? ST_INSERT : ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (pend_r && hit) begin
            // hit: drop the read in flight and start aging
            found_r  <= 1'b1;
            slot_r   <= pend_idx_r[IW-1:0];
            rd_idx_r <= '0;
            pend_r   <= 1'b0;
            state_r  <= ST_AGE;
          end else if (pend_r && last) begin
            pend_r  <= 1'b0;
            state_r <= ST_INSERT;
          end else begin
            if (issue) begin
              rd_idx_r <= rd_idx_r + ONE_C;
            end
            pend_r     <= issue;
            pend_idx_r <= rd_idx_r;
          end
        end
        ST_INSERT: begin
          count_r  <= count_r + ONE_C;
          rd_idx_r <= '0;
          pend_r   <= 1'b0;
          state_r  <= ST_AGE;
        end
        ST_AGE: begin
          if (pend_r && keep) begin
            kept_r <= kept_r + ONE_C;
          end
          if (pend_r && last) begin
            pend_r  <= 1'b0;
            state_r <= ST_DONE;
          end else begin
            if (issue) begin
              rd_idx_r <= rd_idx_r + ONE_C;
            end
            pend_r     <= issue;
            pend_idx_r <= rd_idx_r;
          end
        end
        ST_DONE: begin
          // hold until the result register is free
          if (!out_valid_r || out_ready) begin
            out_valid_r   <= 1'b1;
            out_present_r <= found_r;
            out_slot_r    <= slot_ext[3:0];
            out_entries_r <= kept_ext[4:0];
            out_removed_r <= removed_ext[4:0];
            entry_count_r <= kept_r;
            state_r       <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  a_compact_write_below_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_AGE && mem_we) |-> (kept_r < pend_idx_r))
    else $error("compaction write does not lie below the entry being read");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    entry_count_r <= DEPTH_C)
    else $error("entry count exceeds table depth");

  a_kept_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> (kept_r <= count_r))
    else $error("more entries kept than present");

  a_clamped_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_valid) |=> (count_r < DEPTH_C))
    else $error("search count not clamped below depth");

endmodule

@@ src/address_cache_with_aging.sv @@
// Top level of the address cache with aging: register file, entry store, sequencer.
// Depends on acwa_pkg, acwa_cfg, acwa_mem and acwa_ctrl.
//
//   channel  direction  handshake           payload
//   in       in         in_valid/in_ready   in_sender_ip, in_sender_mac, in_now
//   out      out        out_valid/out_ready out_was_present, out_write_slot,
//                                           out_entries_after, out_removed_count
//   cfg      in         psel/penable/pready paddr, pwrite, pwdata, prdata
//
// One word at a time. The n entries searched are the entry count, clamped to 15 on a
// full table of 16. The single read port of the entry store is read once per entry
// in the search pass, which ends early at a match, and once in the aging pass.
// Reset clears the entry count, the sequencer and the result valid; entries are never
// read before they are written.
// A stalled result holds in the output register; the next word is taken meanwhile and
// processed up to its result, which then waits for the register to free.
module address_cache_with_aging #(
  parameter int TABLE_DEPTH = acwa_pkg::DEFAULT_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [acwa_pkg::IP_W-1:0]    in_sender_ip,
  input  logic [acwa_pkg::MAC_W-1:0]   in_sender_mac,
  input  logic [acwa_pkg::TIME_W-1:0]  in_now,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_was_present,
  output logic [3:0]                   out_write_slot,
  output logic [4:0]                   out_entries_after,
  output logic [4:0]                   out_removed_count,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [acwa_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [acwa_pkg::TIME_W-1:0] age_limit;
  logic                        mem_we;
  logic [IW-1:0]               mem_waddr;
  logic [IW-1:0]               mem_raddr;
  acwa_pkg::entry_t            mem_wdata;
  acwa_pkg::entry_t            mem_rdata;

  acwa_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .age_limit (age_limit)
  );

  acwa_mem #(
    .DEPTH (TABLE_DEPTH),
    .IW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  acwa_ctrl #(
    .DEPTH (TABLE_DEPTH),
    .IW    (IW),
    .CW    (CW)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sender_ip      (in_sender_ip),
    .in_sender_mac     (in_sender_mac),
    .in_now            (in_now),
    .age_limit         (age_limit),
    .mem_we            (mem_we),
    .mem_waddr         (mem_waddr),
    .mem_wdata         (mem_wdata),
    .mem_raddr         (mem_raddr),
    .mem_rdata         (mem_rdata),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_was_present   (out_was_present),
    .out_write_slot    (out_write_slot),
    .out_entries_after (out_entries_after),
    .out_removed_count (out_removed_count)
  );

endmodule
